// ----- hdl/hht_pkg.sv -----
// Package for the hopscotch hash table: defaults, FNV-1a constants, status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package hht_pkg;

  localparam int SlotsDef     = 1024;
  localparam int NeighborDef  = 32;
  localparam int KeyBytesDef  = 8;
  localparam int ValueBitsDef = 32;

  localparam int KeyW    = 64;
  localparam int ValW    = 32;
  localparam int ScopeW  = 32;
  localparam int CountW  = 11;

  localparam logic [63:0] FnvBasis   = 64'hcbf29ce484222325;
  // prime = 2^40 + 0x1b3
  localparam logic [63:0] FnvPrimeLo = 64'h00000000000001b3;
  localparam int          FnvShift   = 40;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_HSTART,
    CS_HASH,
    CS_LK_A,
    CS_LK_B,
    CS_FS_A,
    CS_FS_B,
    CS_NEAR,
    CS_INS,
    CS_MV_A,
    CS_MV_B,
    CS_MV_HASH,
    CS_MV_CHK,
    CS_MV_WR,
    CS_MV_FREE,
    CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    clr_wr;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_load_top;
    logic    latch;
    logic    hash_start;
    logic    hash_src_y;
    logic    home_load;
    logic    yh_load;
    logic    rd_below;
    logic    hop_yh;
    logic    upd_wr;
    logic    fv_load;
    logic    free_load;
    logic    ins_wr;
    logic    mv_wr;
    logic    mv_free;
    logic    out_load;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic idx_last_slot;
    logic idx_last_nb;
    logic idx_one;
    logic probe_hit;
    logic slot_used;
    logic near;
    logic nd_ok;
    logic out_free;
    logic op_lookup;
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/hht_hash.sv -----
// FNV-1a 64 home-bucket unit: one key byte per cycle, then the remainder by the
// slot count one hash byte per cycle by reciprocal multiplication. Depends on hht_pkg.
`default_nettype none

module hht_hash
  import hht_pkg::*;
#(
  parameter int SLOTS     = SlotsDef,
  parameter int KEY_BYTES = KeyBytesDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [KeyW-1:0]            key_i,
  output logic                            done_o,
  output logic [$clog2(SLOTS)-1:0]        home_o
);

  localparam int AW    = $clog2(SLOTS);
  localparam int STEPS = KEY_BYTES + 8;
  localparam int CW    = $clog2(STEPS + 1);
  // remainder digit: x = r * 256 + byte, x < 256 * SLOTS
  localparam int XW    = AW + 8;
  localparam int RS    = 2 * AW + 8;
  localparam int MW    = AW + 10;
  localparam logic [63:0] RecipFull =
    ((64'd1 << RS) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [MW-1:0] Recip     = RecipFull[MW-1:0];
  localparam logic [CW-1:0] ByteSteps = CW'(KEY_BYTES);
  localparam logic [CW-1:0] LastStep  = CW'(STEPS - 1);
  localparam logic [XW-1:0] SlotsX    = XW'(SLOTS);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [63:0]   h_q, kq_q;
  logic [AW-1:0] r_q;

  logic [7:0]       cur_byte;
  logic [63:0]      hx, h_mul, h_byte_d;
  logic             byte_phase;
  logic [XW-1:0]    rx, qd, rem;
  logic [XW+MW-1:0] prod;
  logic [7:0]       quo;

  always_comb begin
    cur_byte   = kq_q[{cnt_q[2:0], 3'b000} +: 8];
    hx         = h_q ^ {56'd0, cur_byte};
    h_mul      = hx * FnvPrimeLo;
    h_byte_d   = (hx << FnvShift) + h_mul;
    byte_phase = cnt_q < ByteSteps;
    // exact quotient of x by SLOTS, then the remainder
    rx         = {r_q, h_q[63:56]};
    prod       = {{MW{1'b0}}, rx} * {{XW{1'b0}}, Recip};
    quo        = prod[RS +: 8];
    qd         = {{AW{1'b0}}, quo} * SlotsX;
    rem        = rx - qd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q  <= FnvBasis;
      kq_q <= key_i;
      r_q  <= '0;
    end else if (busy_q) begin
      if (byte_phase) begin
        h_q <= h_byte_d;
      end else begin
        h_q <= {h_q[55:0], 8'd0};
        r_q <= rem[AW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign home_o = r_q;

endmodule

`default_nettype wire

// ----- hdl/hht_ctrl.sv -----
// Controller for the hopscotch hash table: sequences clear, hash, probe,
// free-slot scan and displacement. Depends on hht_pkg.
`default_nettype none

module hht_ctrl
  import hht_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  status_e     st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
      st_q    <= ST_MISSING;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    cmd_o      = '0;
    cmd_o.status = st_q;
    in_stall_o = (state_q != CS_IDLE);
    case (state_q)
      CS_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.idx_last_slot) begin
          cmd_o.idx_clr = 1'b1;
          state_d = CS_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d = CS_HSTART;
        end
      end
      CS_HSTART: begin
        cmd_o.hash_start = 1'b1;
        state_d = CS_HASH;
      end
      CS_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.home_load = 1'b1;
          state_d = CS_LK_A;
        end
      end
      CS_LK_A: state_d = CS_LK_B;
      CS_LK_B: begin
        if (sts_i.probe_hit) begin
          if (sts_i.op_lookup) begin
            cmd_o.fv_load = 1'b1;
            st_d = ST_FOUND;
          end else begin
            cmd_o.upd_wr = 1'b1;
            st_d = ST_UPDATED;
          end
          state_d = CS_DONE;
        end else if (sts_i.idx_last_nb) begin
          if (sts_i.op_lookup) begin
            st_d = ST_MISSING;
            state_d = CS_DONE;
          end else begin
            cmd_o.idx_clr = 1'b1;
            state_d = CS_FS_A;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = CS_LK_A;
        end
      end
      CS_FS_A: state_d = CS_FS_B;
      CS_FS_B: begin
        if (!sts_i.slot_used) begin
          cmd_o.free_load = 1'b1;
          state_d = CS_NEAR;
        end else if (sts_i.idx_last_slot) begin
          st_d = ST_FULL;
          state_d = CS_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = CS_FS_A;
        end
      end
      CS_NEAR: begin
        if (sts_i.near) begin
          state_d = CS_INS;
        end else begin
          cmd_o.idx_load_top = 1'b1;
          state_d = CS_MV_A;
        end
      end
      CS_INS: begin
        cmd_o.ins_wr = 1'b1;
        st_d = ST_INSERTED;
        state_d = CS_DONE;
      end
      CS_MV_A: begin
        cmd_o.rd_below = 1'b1;
        state_d = CS_MV_B;
      end
      CS_MV_B: begin
        cmd_o.rd_below = 1'b1;
        if (sts_i.slot_used) begin
          cmd_o.hash_start = 1'b1;
          cmd_o.hash_src_y = 1'b1;
          state_d = CS_MV_HASH;
        end else if (sts_i.idx_one) begin
          st_d = ST_FULL;
          state_d = CS_DONE;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d = CS_MV_A;
        end
      end
      CS_MV_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.yh_load = 1'b1;
          state_d = CS_MV_CHK;
        end
      end
      CS_MV_CHK: begin
        cmd_o.hop_yh = 1'b1;
        if (sts_i.nd_ok) begin
          state_d = CS_MV_WR;
        end else if (sts_i.idx_one) begin
          st_d = ST_FULL;
          state_d = CS_DONE;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d = CS_MV_A;
        end
      end
      CS_MV_WR: begin
        cmd_o.hop_yh = 1'b1;
        cmd_o.mv_wr  = 1'b1;
        state_d = CS_MV_FREE;
      end
      CS_MV_FREE: begin
        cmd_o.mv_free = 1'b1;
        state_d = CS_NEAR;
      end
      CS_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/hht_dp.sv -----
// Datapath for the hopscotch hash table: slot, used and hop-map memories,
// address arithmetic, hash unit and output register. Depends on hht_pkg, hht_hash.
`default_nettype none

module hht_dp
  import hht_pkg::*;
#(
  parameter int SLOTS        = SlotsDef,
  parameter int NEIGHBORHOOD = NeighborDef,
  parameter int KEY_BYTES    = KeyBytesDef,
  parameter int VALUE_BITS   = ValueBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic              operation_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [ValW-1:0]   value_i,
  input  wire logic [ScopeW-1:0] tag_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [ValW-1:0]        found_value_o,
  output logic [CountW-1:0]      entry_count_o
);

  localparam int AW = $clog2(SLOTS);
  localparam int VW = (VALUE_BITS > ValW) ? ValW : VALUE_BITS;
  localparam int EW = KeyW + VW + ScopeW;
  localparam int NB = NEIGHBORHOOD;
  localparam logic [KeyW-1:0] KeyMask  = {KeyW{1'b1}} >> (KeyW - 8 * KEY_BYTES);
  localparam logic [AW:0]     SlotsW   = (AW+1)'(SLOTS);
  localparam logic [AW:0]     NbW      = (AW+1)'(NB);
  localparam logic [AW-1:0]   LastSlot = AW'(SLOTS - 1);
  localparam logic [AW-1:0]   NbTop    = AW'(NB - 1);
  localparam logic [NB-1:0]   NbOne    = NB'(1);

  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SlotsW) s = s - SlotsW;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) s = s + SlotsW;
    return s[AW-1:0];
  endfunction

  // memories
  logic [EW-1:0] ent_mem  [SLOTS];
  logic          used_mem [SLOTS];
  logic [NB-1:0] hop_mem  [SLOTS];
  logic [EW-1:0] ent_rd_q;
  logic          used_rd_q;
  logic [NB-1:0] hop_rd_q;

  logic              op_q;
  logic [KeyW-1:0]   key_q;
  logic [VW-1:0]     val_q;
  logic [ScopeW-1:0] sc_q;
  logic [AW-1:0]     idx_q, home_q, yh_q, f_q;
  logic [EW-1:0]     y_q;
  logic [VW-1:0]     fv_q;
  logic [CountW-1:0] count_q;
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [ValW-1:0]   fv_out_q;
  logic [CountW-1:0] cnt_out_q;

  logic [AW-1:0]   probe, below, slot_ra, hop_ra;
  logic [AW-1:0]   d_home, d_nd, d_od;
  logic            od_ok;
  logic            ent_we, used_we, used_wd, hop_we;
  logic [AW-1:0]   ent_wa, used_wa, hop_wa;
  logic [EW-1:0]   ent_wd, new_ent;
  logic [NB-1:0]   hop_wd;
  logic [KeyW-1:0] hash_key;
  logic            hash_done;
  logic [AW-1:0]   hash_home;

  hht_hash #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  always_comb begin
    probe    = add_mod(home_q, idx_q);
    below    = sub_mod(f_q, idx_q);
    slot_ra  = cmd_i.rd_below ? below : probe;
    hop_ra   = cmd_i.hop_yh ? yh_q : home_q;
    d_home   = sub_mod(f_q, home_q);
    d_nd     = sub_mod(f_q, yh_q);
    d_od     = sub_mod(below, yh_q);
    od_ok    = {1'b0, d_od} < NbW;
    new_ent  = {key_q, val_q, sc_q};
    hash_key = cmd_i.hash_src_y ? ent_rd_q[EW-1 -: KeyW] : key_q;

    ent_we = cmd_i.upd_wr | cmd_i.ins_wr | cmd_i.mv_wr;
    ent_wa = cmd_i.upd_wr ? probe : f_q;
    ent_wd = cmd_i.mv_wr ? y_q : new_ent;

    used_we = cmd_i.clr_wr | cmd_i.ins_wr | cmd_i.mv_wr | cmd_i.mv_free;
    used_wd = cmd_i.ins_wr | cmd_i.mv_wr;
    if (cmd_i.clr_wr)       used_wa = idx_q;
    else if (cmd_i.mv_free) used_wa = below;
    else                    used_wa = f_q;

    hop_we = cmd_i.clr_wr | cmd_i.ins_wr | cmd_i.mv_wr;
    if (cmd_i.clr_wr) begin
      hop_wa = idx_q;
      hop_wd = '0;
    end else if (cmd_i.ins_wr) begin
      hop_wa = home_q;
      hop_wd = hop_rd_q | (NbOne << d_home);
    end else begin
      // drop the old distance bit, set the new one
      hop_wa = yh_q;
      hop_wd = (hop_rd_q & ~(od_ok ? (NbOne << d_od) : '0)) | (NbOne << d_nd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we)  ent_mem[ent_wa]   <= ent_wd;
    if (used_we) used_mem[used_wa] <= used_wd;
    if (hop_we)  hop_mem[hop_wa]   <= hop_wd;
    ent_rd_q  <= ent_mem[slot_ra];
    used_rd_q <= used_mem[slot_ra];
    hop_rd_q  <= hop_mem[hop_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      key_q <= key_i & KeyMask;
      val_q <= value_i[VW-1:0];
      sc_q  <= tag_i;
    end
    if (cmd_i.home_load) home_q <= hash_home;
    if (cmd_i.yh_load)   yh_q   <= hash_home;
    if (cmd_i.free_load) f_q    <= probe;
    else if (cmd_i.mv_free) f_q <= below;
    if (cmd_i.hash_start && cmd_i.hash_src_y) y_q <= ent_rd_q;
    if (cmd_i.latch)        fv_q <= '0;
    else if (cmd_i.fv_load) fv_q <= ent_rd_q[ScopeW +: VW];
    if (cmd_i.out_load) begin
      status_q  <= cmd_i.status;
      fv_out_q  <= ValW'(fv_q);
      cnt_out_q <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr)           idx_q <= '0;
      else if (cmd_i.idx_load_top) idx_q <= NbTop;
      else if (cmd_i.idx_inc)      idx_q <= idx_q + AW'(1);
      else if (cmd_i.idx_dec)      idx_q <= idx_q - AW'(1);
      if (cmd_i.ins_wr) count_q <= count_q + CountW'(1);
      if (cmd_i.out_load)    out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.hash_done     = hash_done;
    sts_o.idx_last_slot = idx_q == LastSlot;
    sts_o.idx_last_nb   = idx_q == NbTop;
    sts_o.idx_one       = idx_q == AW'(1);
    sts_o.probe_hit     = (|(hop_rd_q & (NbOne << idx_q))) && used_rd_q &&
                          (ent_rd_q[EW-1 -: KeyW] == key_q);
    sts_o.slot_used     = used_rd_q;
    sts_o.near          = {1'b0, d_home} < NbW;
    sts_o.nd_ok         = {1'b0, d_nd} < NbW;
    sts_o.out_free      = !out_valid_q || !out_stall_i;
    sts_o.op_lookup     = op_q;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = fv_out_q;
  assign entry_count_o = cnt_out_q;

endmodule

`default_nettype wire

// ----- hdl/hopscotch_hash_table.sv -----
// Top level of the hopscotch hash table: controller, datapath and checks.
// Depends on hht_pkg, hht_ctrl, hht_dp (which holds hht_hash).
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_stall_o   operation, key, value, tag
//   out      source     out_valid_o / out_stall_i status, found_value, entry_count
//
// One word at a time: accept, then hashing (FNV-1a one key byte a cycle, then
// the remainder one hash byte a cycle), a probe of up to NEIGHBORHOOD slots of
// the neighborhood, each one memory read, and a load of the output register.
// An insert that misses adds a free scan, one memory read per slot, a step to
// place the entry, and per displacement candidate a memory read, plus a rehash
// and check of an occupied one; a move writes the entry and frees the old slot.
// After reset a clearing pass zeroes the used flags and hop maps of all SLOTS
// slots; in_stall_o stays high through it.
// A finished word waits in the output register; a stalled output only holds
// the block at the end of the next word.
`default_nettype none

module hopscotch_hash_table
  import hht_pkg::*;
#(
  parameter int SLOTS        = SlotsDef,
  parameter int NEIGHBORHOOD = NeighborDef,
  parameter int KEY_BYTES    = KeyBytesDef,
  parameter int VALUE_BITS   = ValueBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              operation_i,
  input  wire logic [KeyW-1:0]   key_i,
  input  wire logic [ValW-1:0]   value_i,
  input  wire logic [ScopeW-1:0] tag_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [ValW-1:0]        found_value_o,
  output logic [CountW-1:0]      entry_count_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: clear, hash, probe, scan, displace
  hht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, address math, hash unit, output register
  hht_dp #(
    .SLOTS        (SLOTS),
    .NEIGHBORHOOD (NEIGHBORHOOD),
    .KEY_BYTES    (KEY_BYTES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .tag_i         (tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o)
  );

  // no word taken while the clearing pass runs
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> in_stall_o)
    else $error("word accepted during clearing pass");

  // table writes never collide
  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_wr, cmd.upd_wr, cmd.ins_wr, cmd.mv_wr, cmd.mv_free}))
    else $error("conflicting table writes");

  // a result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

  // hold a stalled result word unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o) &&
      $stable(found_value_o) && $stable(entry_count_o)))
    else $error("stalled result word changed");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the hopscotch hash table: directed and random
// insert/lookup words against a table predictor held in a small scoreboard class.
// Depends on hht_pkg and the hopscotch_hash_table RTL.
`default_nettype none

module testbench;
  import hht_pkg::*;

  localparam int NbSlots    = SlotsDef;
  localparam int NbHood     = NeighborDef;
  localparam int RandWords  = 1530;
  localparam int IdleLimit  = 4000000;
  localparam int LongHold   = 3000;
  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

  // Table predictor and store of expected result words.
  class hop_table_sb;
    logic [63:0] tbl_key[NbSlots];
    logic [31:0] tbl_val[NbSlots];
    logic [31:0] tbl_scope[NbSlots];
    bit          tbl_used[NbSlots];
    logic [31:0] hop_map[NbSlots];
    int          occupied;
    status_e     want_status[$];
    logic [31:0] want_value[$];
    logic [10:0] want_count[$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < NbSlots; i++) begin
        tbl_used[i] = 0;
        hop_map[i]  = '0;
      end
      occupied = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    // FNV-1a 64 over the key bytes, low byte first, reduced to a bucket
    function int home_bucket(logic [63:0] k);
      logic [63:0] h;
      h = 64'hcbf29ce484222325;
      for (int b = 0; b < 8; b++) begin
        h = h ^ {56'd0, k[8*b +: 8]};
        h = h * 64'h100000001b3;
      end
      return int'(h % NbSlots);
    endfunction

    function int span(int from, int upto);
      return (upto >= from) ? upto - from : upto + NbSlots - from;
    endfunction

    // slot that holds k among those marked in the home map, -1 if none
    function int locate(int hm, logic [63:0] k);
      for (int d = 0; d < NbHood; d++) begin
        if (hop_map[hm][d]) begin
          if (tbl_used[(hm + d) % NbSlots] && tbl_key[(hm + d) % NbSlots] == k)
            return (hm + d) % NbSlots;
        end
      end
      return -1;
    endfunction

    function status_e insert_key(logic [63:0] k, logic [31:0] v, logic [31:0] sc);
      int hm, s, hole, d, y, yh, nd, od;
      bit moved;
      hm = home_bucket(k);
      s  = locate(hm, k);
      if (s >= 0) begin
        tbl_val[s]   = v;
        tbl_scope[s] = sc;
        return ST_UPDATED;
      end
      hole = -1;
      for (int i = 0; i < NbSlots; i++) begin
        if (!tbl_used[(hm + i) % NbSlots]) begin
          hole = (hm + i) % NbSlots;
          break;
        end
      end
      if (hole < 0) return ST_FULL;
      forever begin
        d = span(hm, hole);
        if (d < NbHood) begin
          tbl_key[hole]   = k;
          tbl_val[hole]   = v;
          tbl_scope[hole] = sc;
          tbl_used[hole]  = 1;
          hop_map[hm][d]  = 1'b1;
          occupied++;
          return ST_INSERTED;
        end
        // hop an earlier entry forward into the hole; moves already done stay
        moved = 0;
        for (int i = NbHood - 1; i > 0; i--) begin
          y = (hole + NbSlots - i) % NbSlots;
          if (!tbl_used[y]) continue;
          yh = home_bucket(tbl_key[y]);
          nd = span(yh, hole);
          if (nd < NbHood) begin
            od = span(yh, y);
            if (od < NbHood) hop_map[yh][od] = 1'b0;
            hop_map[yh][nd] = 1'b1;
            tbl_key[hole]   = tbl_key[y];
            tbl_val[hole]   = tbl_val[y];
            tbl_scope[hole] = tbl_scope[y];
            tbl_used[hole]  = 1;
            tbl_used[y]     = 0;
            hole  = y;
            moved = 1;
            break;
          end
        end
        if (!moved) return ST_FULL;
      end
    endfunction

    function void note_word(logic op, logic [63:0] k, logic [31:0] v, logic [31:0] sc);
      status_e st;
      logic [31:0] fv;
      int s;
      fv = '0;
      if (op == OpInsert) begin
        st = insert_key(k, v, sc);
      end else begin
        s = locate(home_bucket(k), k);
        if (s >= 0) begin
          st = ST_FOUND;
          fv = tbl_val[s];
        end else begin
          st = ST_MISSING;
        end
      end
      want_status.push_back(st);
      want_value.push_back(fv);
      want_count.push_back(occupied[10:0]);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [2:0] st, logic [31:0] fv, logic [10:0] cnt);
      checked++;
      if (want_status.size() == 0) begin
        report($sformatf("result word with nothing pending: status %0d", st));
        return;
      end
      if (st !== want_status[0])
        report($sformatf("word %0d status %0d, want %0d", checked, st, want_status[0]));
      if (fv !== want_value[0])
        report($sformatf("word %0d found_value %h, want %h", checked, fv, want_value[0]));
      if (cnt !== want_count[0])
        report($sformatf("word %0d entry_count %0d, want %0d", checked, cnt, want_count[0]));
      void'(want_status.pop_front());
      void'(want_value.pop_front());
      void'(want_count.pop_front());
    endtask

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic        operation_i = 0;
  logic [63:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic [31:0] tag_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  status_o;
  logic [31:0] found_value_o;
  logic [10:0] entry_count_o;

  hop_table_sb sb = new();
  logic [63:0] known_keys[$];
  int          idle_cycles = 0;
  bit          long_hold_done = 0;

  hopscotch_hash_table u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .key_i, .value_i,
    .tag_i, .out_valid_o, .out_stall_i, .status_o, .found_value_o, .entry_count_o
  );

  always #4 clk_i = ~clk_i;

  // Sample both handshakes at the edge; the idle watchdog lives here too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(status_o, found_value_o, entry_count_o);
      if (in_valid_i && !in_stall_o)
        sb.note_word(operation_i, key_i, value_i, tag_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("hopscotch_hash_table test failed");
        $finish;
      end
    end
  end

  // Offer one word after an optional gap; hold it until taken.
  task automatic send_word(logic op, logic [63:0] k, logic [31:0] v, logic [31:0] sc,
                           int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= k;
    value_i     <= v;
    tag_i       <= sc;
    if (op == OpInsert) known_keys.push_back(k);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: mostly ready, short and long stalls, and one long hold-off
  // while the sender keeps offering so the block backs up.
  initial begin
    int r;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (!long_hold_done && sb.checked >= 400) begin
        long_hold_done = 1;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ((sb.checked / 150) % 4 == 3 || r < 75) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat ((r < 97) ? $urandom_range(1, 4) : $urandom_range(20, 200)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [63:0] k;
    logic        op;
    int          r;
    bit          calm;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, update, hit and miss
    send_word(OpLookup, 64'd0, 32'd0, 32'd0, 0);
    send_word(OpInsert, 64'd0, 32'd0, 32'd0, 0);
    send_word(OpInsert, '1, '1, '1, 0);
    send_word(OpLookup, 64'd0, '1, '1, 0);
    send_word(OpLookup, '1, 32'd0, 32'd0, 1);
    send_word(OpInsert, 64'd0, 32'h5a5a_a5a5, 32'h8000_0001, 0);
    send_word(OpLookup, 64'd0, 32'd0, 32'd0, 0);
    send_word(OpInsert, '1, 32'h8000_0000, 32'h0000_0001, 3);
    send_word(OpLookup, '1, 32'd0, 32'd0, 0);
    send_word(OpLookup, 64'h8000_0000_0000_0001, 32'd0, 32'd0, 0);
    send_word(OpInsert, 64'h0000_0000_0000_0001, 32'h0000_0001, 32'd0, 0);
    send_word(OpInsert, 64'h0100_0000_0000_0000, 32'h7fff_ffff, 32'hffff_fffe, 0);
    send_word(OpLookup, 64'h0100_0000_0000_0000, 32'd0, 32'd0, 0);
    send_word(OpLookup, 64'h0000_0000_0000_0001, 32'd0, 32'd0, 0);
    send_word(OpLookup, 64'h0000_0000_0000_0002, 32'd0, 32'd0, 0);

    // random: insert-heavy so the table fills toward displacement and full
    for (int i = 0; i < RandWords; i++) begin
      calm = ((i / 100) % 3 == 1);
      if (i == 700) begin
        // drain: pause until every pending result is back
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      r  = $urandom_range(0, 99);
      op = (r < 72) ? OpInsert : OpLookup;
      if (op == OpInsert)
        k = ($urandom_range(0, 99) < 15) ? known_keys[$urandom_range(0, known_keys.size() - 1)]
                                          : rand_key();
      else
        k = ($urandom_range(0, 99) < 55) ? known_keys[$urandom_range(0, known_keys.size() - 1)]
                                          : rand_key();
      send_word(op, k, $urandom(), $urandom(), pick_gap(calm));
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0)
      $display("hopscotch_hash_table test passed");
    else
      $display("hopscotch_hash_table test failed");
    $finish;
  end

endmodule

`default_nettype wire
